@@ sv/gossip_membership_table_macros.svh @@
// assertion macros for the gossip membership table
// no dependencies; included by the top level only
`ifndef GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH
`define GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH

// same-cycle implication
`define GMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/gmt_pkg.sv @@
// shared types and constants of the gossip membership table
// no dependencies
`default_nettype none

package gmt_pkg;

   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // at most this many removals per tick
   localparam int unsigned RESULT_CAP = 32;
   localparam int unsigned CNT_W      = $clog2(RESULT_CAP + 1);

   localparam logic [31:0] HB_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_JOIN   = 2'd0,
      FUNC_PING   = 2'd1,
      FUNC_GOSSIP = 2'd2,
      FUNC_TICK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      EVT_ADD    = 2'd0,
      EVT_REMOVE = 2'd1,
      EVT_FULL   = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CSR_TIMEOUT   = 2'd0,
      CSR_SELF_ID   = 2'd1,
      CSR_SELF_PORT = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] heartbeat;
      logic [31:0] last_seen;
   } slot_type;

endpackage

`default_nettype wire

@@ sv/gossip_membership_table.sv @@
// gossip membership table: member slots kept in a memory, scanned slot by slot
// depends on gmt_pkg and gossip_membership_table_macros.svh
//
// usage
//   req channel: one transfer per operation. tuser carries func (join, ping,
//   gossip merge, tick), tdata carries now_time, peer fields and the gossiped
//   entry. req_tready is high only while the sequencer is idle.
//   rsp channel: one transfer per event (member added, member removed, table
//   full). tlast marks the last event caused by one request; a request with
//   no event gives no transfer.
//   csr port: write-only, taken on csr_we; user keeps block idle, unenforced
// scan
//   the sequencer scans the slot memory slot by slot, reading then
//   evaluating each one; a lookup stops at the matching slot, a tick stops
//   after its removal cap
// reset
//   synchronous; all slots become free, registers return to timeout 20 and
//   self address 0. no clearing pass: slot valid bits live in flip-flops
// stall
//   a single output register holds each event; when the receiver stalls and a
//   new event is due, the scan waits in place until the register drains
`default_nettype none
`include "gossip_membership_table_macros.svh"

module gossip_membership_table #(
   parameter int MAX_MEMBERS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_time[31:0], peer_id[63:32], peer_port[79:64],
   // entry_heartbeat[111:80], entry_time[143:112]
   input  logic [gmt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[1:0]
   input  logic [gmt_pkg::FUNC_W-1:0]        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // member_id[31:0], member_port[47:32]
   output logic [gmt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // event_kind[1:0]
   output logic [gmt_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast,
   // configuration write port
   input  logic                              csr_we,
   input  logic [gmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gmt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import gmt_pkg::*;

   localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_MEMBERS - 1);

   // configuration registers
   logic [15:0] timeout_ff;
   logic [31:0] self_id_ff;
   logic [15:0] self_port_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // latched request
   func_type    func_ff, func_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] id_ff, id_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] ehb_ff, ehb_in;
   logic [31:0] etime_ff, etime_in;

   // scan results
   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic [31:0]      match_hb_ff, match_hb_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] rm_cnt_ff, rm_cnt_in;

   // removal waiting until we know whether it is the last one
   logic        pend_valid_ff, pend_valid_in;
   logic [31:0] pend_id_ff, pend_id_in;
   logic [15:0] pend_port_ff, pend_port_in;

   // slot storage
   logic [MAX_MEMBERS-1:0] valid_ff, valid_in;
   slot_type               slot_mem_ff [MAX_MEMBERS];
   slot_type               rd_slot_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   slot_type               mem_wdata;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_port_ff, rsp_port_in;
   event_type   rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        push;
   event_type   push_kind;
   logic [31:0] push_id;
   logic [15:0] push_port;
   logic        push_last;

   // shared age unit: one subtract and compare, slot age during scan,
   // gossip entry age at finish
   logic [31:0] age_base;
   logic [31:0] age;
   logic        age_young;

   // per-slot evaluation
   logic cur_valid, hit, stale, at_last, can_push, is_tick, eval_hold, cap_hit;
   logic is_self, ins_ok, fin_hold;

   assign age_base  = (state_ff == ST_EVAL) ? rd_slot_ff.last_seen : etime_ff;
   assign age       = now_ff - age_base;
   assign age_young = age < {16'b0, timeout_ff};

   assign cur_valid = valid_ff[idx_ff];
   assign hit       = cur_valid && (rd_slot_ff.id == id_ff) && (rd_slot_ff.port == port_ff);
   assign stale     = cur_valid && !age_young;
   assign at_last   = (idx_ff == LAST_IDX);
   assign can_push  = !rsp_valid_ff || rsp_tready;
   assign is_tick   = (func_ff == FUNC_TICK);
   assign eval_hold = stale && pend_valid_ff && !can_push;
   assign cap_hit   = stale && (rm_cnt_ff == CNT_W'(RESULT_CAP - 1));
   assign is_self   = (id_ff == self_id_ff) && (port_ff == self_port_ff);
   assign ins_ok    = (func_ff != FUNC_GOSSIP) || (!is_self && age_young);
   assign fin_hold  = !found_ff && ins_ok && !can_push;

   // configuration writes; index three means nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= 16'd20;
         self_id_ff   <= 32'd0;
         self_port_ff <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
            CSR_SELF_ID:   self_id_ff   <= csr_wdata;
            CSR_SELF_PORT: self_port_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (is_tick) begin
               if (!eval_hold) begin
                  state_in = (cap_hit || at_last) ? ST_FLUSH : ST_READ;
               end
            end else begin
               state_in = (hit || at_last) ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            if (!fin_hold) state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (!(pend_valid_ff && !can_push)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      idx_in        = idx_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      id_in         = id_ff;
      port_in       = port_ff;
      ehb_in        = ehb_ff;
      etime_in      = etime_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_hb_in   = match_hb_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rm_cnt_in     = rm_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_port_in  = pend_port_ff;
      valid_in      = valid_ff;
      mem_we        = 1'b0;
      mem_waddr     = match_idx_ff;
      mem_wdata     = '{id: id_ff, port: port_ff, heartbeat: ehb_ff, last_seen: now_ff};
      push          = 1'b0;
      push_kind     = EVT_REMOVE;
      push_id       = pend_id_ff;
      push_port     = pend_port_ff;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in       = func_type'(req_tuser);
               now_in        = req_tdata[31:0];
               id_in         = req_tdata[63:32];
               port_in       = req_tdata[79:64];
               ehb_in        = req_tdata[111:80];
               etime_in      = req_tdata[143:112];
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               rm_cnt_in     = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_READ: ;
         ST_EVAL: begin
            if (is_tick) begin
               if (stale && !eval_hold) begin
                  // the previous removal is known not to be the last
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_slot_ff.id;
                  pend_port_in  = rd_slot_ff.port;
                  valid_in[idx_ff] = 1'b0;
                  rm_cnt_in     = CNT_W'(rm_cnt_ff + 1'b1);
               end
               if (!eval_hold && !cap_hit && !at_last) idx_in = IDX_W'(idx_ff + 1'b1);
            end else begin
               if (hit) begin
                  found_in     = 1'b1;
                  match_idx_in = idx_ff;
                  match_hb_in  = rd_slot_ff.heartbeat;
               end else begin
                  if (!cur_valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
                  if (!at_last) idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         ST_FINISH: begin
            if (found_ff) begin
               if (func_ff == FUNC_PING) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{id: id_ff, port: port_ff, last_seen: now_ff,
                                heartbeat: (match_hb_ff == HB_MAX) ? HB_MAX
                                           : match_hb_ff + 32'd1};
               end else if (func_ff == FUNC_GOSSIP && ehb_ff > match_hb_ff) begin
                  mem_we = 1'b1;
               end
            end else if (ins_ok && can_push) begin
               push      = 1'b1;
               push_kind = free_found_ff ? EVT_ADD : EVT_FULL;
               push_id   = id_ff;
               push_port = port_ff;
               push_last = 1'b1;
               if (free_found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = free_idx_ff;
                  // gossip keeps the entry's own heartbeat and time
                  if (func_ff == FUNC_GOSSIP) begin
                     mem_wdata = '{id: id_ff, port: port_ff, heartbeat: ehb_ff,
                                   last_seen: etime_ff};
                  end else begin
                     mem_wdata = '{id: id_ff, port: port_ff, heartbeat: 32'd1,
                                   last_seen: now_ff};
                  end
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && can_push) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // output register: loads on push, drains on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = push_id;
         rsp_port_in  = push_port;
         rsp_kind_in  = push_kind;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_port_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rm_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rm_cnt_ff     <= rm_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      func_ff       <= func_in;
      now_ff        <= now_in;
      id_ff         <= id_in;
      port_ff       <= port_in;
      ehb_ff        <= ehb_in;
      etime_ff      <= etime_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      match_hb_ff   <= match_hb_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      pend_id_ff    <= pend_id_in;
      pend_port_ff  <= pend_port_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // slot memory: one write port, one registered read port at the scan index
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem_ff[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= slot_mem_ff[idx_ff];
   end

   // checks
   `GMT_ASSERT_IMPL(a_insert_free, clock, reset, mem_we && !found_ff, !valid_ff[mem_waddr], "insert hit a live slot")
   `GMT_ASSERT_NEXT(a_tick_shrinks, clock, reset, state_ff == ST_EVAL && func_ff == FUNC_TICK, $countones(valid_ff) <= $countones($past(valid_ff)), "tick added a member")
   `GMT_ASSERT_IMPL(a_rm_cap, clock, reset, 1'b1, rm_cnt_ff <= CNT_W'(RESULT_CAP), "removal count beyond cap")
   `GMT_ASSERT_IMPL(a_no_overrun, clock, reset, push, !rsp_valid_ff || rsp_tready, "event overwrote a waiting result")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// self-checking bench for gossip_membership_table: directed and random join, ping,
// gossip merge and tick traffic, each event checked against a behavioral table model
// depends on gmt_pkg and the gossip_membership_table rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmt_pkg::*;

   localparam int TABLE_DEPTH   = 32;
   // time for a full scan plus overhead, with margin
   localparam int SETTLE_CYCLES = 100;
   // cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT   = 3000;
   localparam int POOL_SIZE     = 40;
   localparam int PRINT_LIMIT   = 100;

   typedef struct {
      func_type    func;
      logic [31:0] now_time;
      logic [31:0] peer_id;
      logic [15:0] peer_port;
      logic [31:0] entry_hb;
      logic [31:0] entry_time;
   } member_req_type;

   typedef struct {
      event_type   kind;
      logic [31:0] id;
      logic [15:0] port;
      logic        last;
   } member_event_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // dut ports, all known from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // now_time[31:0], peer_id[63:32], peer_port[79:64],
   // entry_heartbeat[111:80], entry_time[143:112]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // func[1:0]
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // member_id[31:0], member_port[47:32]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // event_kind[1:0]
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   gossip_membership_table #(
      .MAX_MEMBERS(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // model of the member table and its registers
   logic        tbl_valid [TABLE_DEPTH];
   logic [31:0] tbl_id    [TABLE_DEPTH];
   logic [15:0] tbl_port  [TABLE_DEPTH];
   logic [31:0] tbl_hb    [TABLE_DEPTH];
   logic [31:0] tbl_seen  [TABLE_DEPTH];
   logic [15:0] cfg_timeout;
   logic [31:0] cfg_self_id;
   logic [15:0] cfg_self_port;

   // requests waiting for the driver, events waiting for the dut
   member_req_type   pending_reqs[$];
   member_event_type membership_events[$];

   member_req_type   req_cur;
   member_event_type exp_ev;
   int               mismatch_count = 0;
   int               events_seen    = 0;
   int               quiet_cycles   = 0;
   bit               no_gaps        = 1'b0;

   // stimulus state: running clock of the cluster and a pool of peer addresses
   logic [31:0] sim_now;
   logic [31:0] pool_id  [POOL_SIZE];
   logic [15:0] pool_port[POOL_SIZE];

   task automatic report_mismatch(string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // lowest free slot takes the member, otherwise the insert is dropped
   function automatic member_event_type add_member(logic [31:0] id, logic [15:0] port,
                                                   logic [31:0] hb, logic [31:0] seen);
      member_event_type ev;
      int               slot;
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!tbl_valid[i] && slot < 0) slot = i;
      ev.id   = id;
      ev.port = port;
      ev.last = 1'b0;
      if (slot < 0) begin
         ev.kind = EVT_FULL;
      end else begin
         ev.kind         = EVT_ADD;
         tbl_valid[slot] = 1'b1;
         tbl_id[slot]    = id;
         tbl_port[slot]  = port;
         tbl_hb[slot]    = hb;
         tbl_seen[slot]  = seen;
      end
      return ev;
   endfunction

   // applies one accepted request to the model and queues the events it causes
   function automatic void predict_request(member_req_type r);
      member_event_type found[$];
      member_event_type ev;
      logic [31:0]      age;
      int               hit;
      hit = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i] && tbl_id[i] == r.peer_id && tbl_port[i] == r.peer_port && hit < 0)
            hit = i;
      case (r.func)
         FUNC_JOIN, FUNC_PING: begin
            if (hit < 0) begin
               found = {found, add_member(r.peer_id, r.peer_port, 32'd1, r.now_time)};
            end else if (r.func == FUNC_PING) begin
               // heartbeat saturates
               if (tbl_hb[hit] != HB_MAX) tbl_hb[hit] = tbl_hb[hit] + 32'd1;
               tbl_seen[hit] = r.now_time;
            end
         end
         FUNC_GOSSIP: begin
            age = r.now_time - r.entry_time;
            if (hit < 0) begin
               // own address is never learned from gossip, stale entries are dropped
               if ((r.peer_id != cfg_self_id || r.peer_port != cfg_self_port) &&
                   age < {16'd0, cfg_timeout})
                  found = {found, add_member(r.peer_id, r.peer_port, r.entry_hb,
                                             r.entry_time)};
            end else if (r.entry_hb > tbl_hb[hit]) begin
               tbl_hb[hit]   = r.entry_hb;
               tbl_seen[hit] = r.now_time;
            end
         end
         default: begin
            // sweep in slot order, removal count capped per tick
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               age = r.now_time - tbl_seen[i];
               if (tbl_valid[i] && age >= {16'd0, cfg_timeout} && found.size() < RESULT_CAP) begin
                  tbl_valid[i] = 1'b0;
                  ev.kind      = EVT_REMOVE;
                  ev.id        = tbl_id[i];
                  ev.port      = tbl_port[i];
                  ev.last      = 1'b0;
                  found        = {found, ev};
               end
            end
         end
      endcase
      foreach (found[k]) begin
         ev                = found[k];
         ev.last           = (k == found.size() - 1);
         membership_events = {membership_events, ev};
      end
   endfunction

   task automatic queue_req(func_type func, logic [31:0] now_time, logic [31:0] id,
                            logic [15:0] port, logic [31:0] hb, logic [31:0] etime);
      member_req_type r;
      r.func       = func;
      r.now_time   = now_time;
      r.peer_id    = id;
      r.peer_port  = port;
      r.entry_hb   = hb;
      r.entry_time = etime;
      pending_reqs = {pending_reqs, r};
   endtask

   // random request: time creeps forward, now and then jumps and sweeps
   function automatic member_req_type rand_req(int pool_n);
      member_req_type r;
      logic [31:0]    span;
      int             roll;
      int             pick;
      span = {16'd0, cfg_timeout};
      roll = $urandom_range(99);
      if (roll < 4) begin
         sim_now = sim_now + span + $urandom_range(span, 0);
         r.func  = FUNC_TICK;
      end else begin
         if (roll < 6) sim_now = $urandom;
         else sim_now = sim_now + $urandom_range(span / 64 + 1, 0);
         roll = $urandom_range(99);
         if (roll < 25) r.func = FUNC_JOIN;
         else if (roll < 50) r.func = FUNC_PING;
         else if (roll < 85) r.func = FUNC_GOSSIP;
         else r.func = FUNC_TICK;
      end
      r.now_time = sim_now;
      if ($urandom_range(9) == 0) begin
         r.peer_id   = $urandom;
         r.peer_port = 16'($urandom_range(16'hFFFF, 0));
      end else begin
         pick        = $urandom_range(pool_n - 1, 0);
         r.peer_id   = pool_id[pick];
         r.peer_port = pool_port[pick];
      end
      case ($urandom_range(3))
         0: r.entry_hb = $urandom_range(8, 0);
         1: r.entry_hb = $urandom;
         2: r.entry_hb = HB_MAX;
         default: r.entry_hb = 32'd0;
      endcase
      // entry ages spread around the timeout so both outcomes occur
      if ($urandom_range(9) == 0) r.entry_time = $urandom;
      else r.entry_time = sim_now - $urandom_range(span + span / 2 + 1, 0);
      return r;
   endfunction

   task automatic write_csr(csr_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_TIMEOUT:   cfg_timeout   = value[15:0];
         CSR_SELF_ID:   cfg_self_id   = value;
         CSR_SELF_PORT: cfg_self_port = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] timeout, logic [31:0] sid, logic [15:0] sport);
      write_csr(CSR_TIMEOUT, {16'd0, timeout});
      write_csr(CSR_SELF_ID, sid);
      write_csr(CSR_SELF_PORT, {16'd0, sport});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // all transfers done and the sequencer given time to finish a silent item
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || membership_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, int pool_n);
      for (int i = 0; i < count; i++)
         pending_reqs = {pending_reqs, rand_req(pool_n)};
      wait_idle();
   endtask

   // request driver: holds a transfer until accepted, predicts at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_request(req_cur);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 15)) begin
               req_cur = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {req_cur.entry_time, req_cur.entry_hb, req_cur.peer_port,
                              req_cur.peer_id, req_cur.now_time};
               req_tuser  <= req_cur.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // event monitor: random backpressure, each transfer checked against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (membership_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d id %h port %h",
                                         rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32]));
            end else begin
               exp_ev = membership_events.pop_front();
               if (rsp_tuser != exp_ev.kind)
                  report_mismatch($sformatf("event %0d kind %0d, want %0d",
                                            events_seen, rsp_tuser, exp_ev.kind));
               if (rsp_tdata[31:0] != exp_ev.id)
                  report_mismatch($sformatf("event %0d id %h, want %h",
                                            events_seen, rsp_tdata[31:0], exp_ev.id));
               if (rsp_tdata[47:32] != exp_ev.port)
                  report_mismatch($sformatf("event %0d port %h, want %h",
                                            events_seen, rsp_tdata[47:32], exp_ev.port));
               if (rsp_tlast != exp_ev.last)
                  report_mismatch($sformatf("event %0d tlast %0b, want %0b",
                                            events_seen, rsp_tlast, exp_ev.last));
            end
            events_seen++;
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= 15);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // model reset state
      cfg_timeout   = 16'd20;
      cfg_self_id   = 32'd0;
      cfg_self_port = 16'd0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_id[i]    = '0;
         tbl_port[i]  = '0;
         tbl_hb[i]    = '0;
         tbl_seen[i]  = '0;
      end

      // peer pool: extremes first, then pairs sharing only an id or only a port
      pool_id[0]   = 32'd0;
      pool_port[0] = 16'd0;
      pool_id[1]   = 32'hFFFF_FFFF;
      pool_port[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) begin
         pool_id[i]   = $urandom;
         pool_port[i] = 16'($urandom_range(16'hFFFF, 0));
         if (i % 4 == 3) pool_id[i] = pool_id[i-1];
         if (i % 4 == 0) pool_port[i] = pool_port[i-1];
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset registers: timeout 20, own address 0:0
      queue_req(FUNC_JOIN,   32'd100, 32'd1, 16'd10, 32'd0, 32'd0);     // add
      queue_req(FUNC_JOIN,   32'd101, 32'd1, 16'd10, 32'd0, 32'd0);     // already present
      queue_req(FUNC_PING,   32'd105, 32'd1, 16'd10, 32'd0, 32'd0);     // heartbeat bump
      queue_req(FUNC_PING,   32'd106, 32'd1, 16'd11, 32'd0, 32'd0);     // same id other port
      queue_req(FUNC_JOIN,   32'd106, 32'd2, 16'd10, 32'd0, 32'd0);     // same port other id
      queue_req(FUNC_GOSSIP, 32'd110, 32'hFFFF_FFFF, 16'hFFFF, HB_MAX, 32'd100);
      queue_req(FUNC_PING,   32'd111, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0); // saturated
      queue_req(FUNC_GOSSIP, 32'd110, 32'd3, 16'd3, 32'd4, 32'd90);     // age equals timeout
      queue_req(FUNC_GOSSIP, 32'd110, 32'd3, 16'd3, 32'd4, 32'd91);     // just fresh enough
      queue_req(FUNC_GOSSIP, 32'd110, 32'd0, 16'd0, 32'd9, 32'd110);    // own address skipped
      queue_req(FUNC_GOSSIP, 32'd112, 32'd1, 16'd10, 32'd1, 32'd112);   // older heartbeat
      queue_req(FUNC_GOSSIP, 32'd120, 32'd1, 16'd10, 32'd7, 32'd115);   // newer heartbeat
      queue_req(FUNC_TICK,   32'd124, 32'd0, 16'd0, 32'd0, 32'd0);      // one removal
      queue_req(FUNC_TICK,   32'd126, 32'd0, 16'd0, 32'd0, 32'd0);      // two removals
      queue_req(FUNC_JOIN,   32'd126, 32'd0, 16'd0, 32'd0, 32'd0);      // join of own address
      queue_req(FUNC_GOSSIP, 32'd130, 32'd0, 16'd0, 32'd5, 32'd130);    // own entry updated
      // time wraps past zero
      queue_req(FUNC_GOSSIP, 32'd5, 32'hDEAD_BEEF, 16'h1234, 32'd2, 32'hFFFF_FFF0);
      queue_req(FUNC_GOSSIP, 32'd5, 32'hDEAD_BEEF, 16'h1234, 32'd2, 32'hFFFF_FFF4);
      queue_req(FUNC_TICK,   32'd6, 32'd0, 16'd0, 32'd0, 32'd0);
      wait_idle();

      // zero timeout, own address all ones
      set_config(16'd0, 32'hFFFF_FFFF, 16'hFFFF);
      queue_req(FUNC_GOSSIP, 32'd200, 32'd5, 16'd5, 32'd3, 32'd200);    // always too old
      queue_req(FUNC_JOIN,   32'd200, 32'd5, 16'd5, 32'd0, 32'd0);
      queue_req(FUNC_GOSSIP, 32'd200, 32'hFFFF_FFFF, 16'hFFFF, 32'd1, 32'd200);
      queue_req(FUNC_TICK,   32'd200, 32'd0, 16'd0, 32'd0, 32'd0);      // everyone stale
      wait_idle();

      // timeout of one, small pool
      set_config(16'd1, pool_id[2], pool_port[2]);
      sim_now = $urandom;
      run_random(60, 6);

      // longest timeout, wide pool: table fills up and sweeps empty it
      set_config(16'hFFFF, pool_id[5], pool_port[5]);
      run_random(110, POOL_SIZE);

      // random registers, no idling on either side
      set_config(16'($urandom_range(400, 2)), $urandom, 16'($urandom_range(16'hFFFF, 0)));
      no_gaps = 1'b1;
      run_random(80, POOL_SIZE);
      no_gaps = 1'b0;

      // clock runs across the wrap point
      set_config(16'd4000, pool_id[1], pool_port[1]);
      sim_now = 32'hFFFF_F800;
      run_random(80, 12);

      set_config(16'hFFFF, pool_id[3], pool_port[3]);
      run_random(90, 24);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/gmt_pkg.sv
sv/gossip_membership_table.sv
dv/tb.sv
